// File: rtl/rwcp_pkg.sv
`default_nettype none

package rwcp_pkg;

    // Reset value of the smallest accepted fmt chunk length.
    localparam logic [7:0] MIN_FORMAT_LENGTH_RESET = 8'd16;

    // Little-endian chunk tags as they appear in the shift word.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Byte position saturates at the top of its range.
    localparam logic [32:0] POS_MAX = {33{1'b1}};

    // Largest number of format bytes captured from the fmt chunk.
    localparam logic [4:0] FORMAT_BYTES = 5'd16;

    // Result status codes.
    localparam logic [2:0] STATUS_COMPLETE  = 3'd0;
    localparam logic [2:0] STATUS_NOT_RIFF  = 3'd1;
    localparam logic [2:0] STATUS_NOT_WAVE  = 3'd2;
    localparam logic [2:0] STATUS_FMT_SHORT = 3'd3;
    localparam logic [2:0] STATUS_END       = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RIFF,
        PH_RLEN,
        PH_WAVE,
        PH_HEAD,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        format_found;
        logic        data_found;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] avg_bytes_per_second;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } result_item_t;

endpackage

`default_nettype wire

// File: rtl/rwcp_core.sv
`default_nettype none

module rwcp_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire rwcp_pkg::byte_item_t  item,
    input  wire logic [7:0]            min_format_length,
    output logic                       emit,
    output rwcp_pkg::result_item_t     result
);

    typedef struct packed {
        rwcp_pkg::phase_t phase;
        logic [32:0]      byte_position;
        logic [32:0]      riff_end;
        logic [31:0]      word_shift;
        logic [31:0]      chunk_tag;
        logic [32:0]      chunk_remaining;
        logic [127:0]     format_bytes;
        logic [1:0]       found_flags;
        logic [31:0]      data_off;
        logic [31:0]      data_len;
        logic [3:0]       sub_count;
        logic [4:0]       capture_left;
        logic [3:0]       capture_index;
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    state_t     cur;
    logic [2:0] status;
    logic       do_boundary;
    logic [31:0] len;

    // One byte of parsing: everything is worked out from the current state and the byte.
    always_comb begin
        cur = state_reg;
        if (item.first_byte) begin
            cur = '0;
            cur.phase = rwcp_pkg::PH_RIFF;
        end
        state_next  = cur;
        emit        = 1'b0;
        status      = rwcp_pkg::STATUS_COMPLETE;
        do_boundary = 1'b0;
        len         = '0;

        if (cur.phase != rwcp_pkg::PH_IDLE && cur.phase != rwcp_pkg::PH_DONE) begin
            if (cur.byte_position != rwcp_pkg::POS_MAX) begin
                state_next.byte_position = cur.byte_position + 33'd1;
            end

            if (cur.phase == rwcp_pkg::PH_BODY) begin
                // Body byte: capture format bytes, then count down the chunk.
                if (cur.capture_left != 5'd0) begin
                    state_next.format_bytes[{cur.capture_index, 3'b000} +: 8] = item.file_byte;
                    state_next.capture_index = cur.capture_index + 4'd1;
                    state_next.capture_left  = cur.capture_left - 5'd1;
                    if (cur.capture_left == 5'd1 && cur.found_flags[1]
                            && cur.data_len != 32'd0) begin
                        emit   = 1'b1;
                        status = rwcp_pkg::STATUS_COMPLETE;
                    end
                end
                if (!emit) begin
                    state_next.chunk_remaining = cur.chunk_remaining - 33'd1;
                    if (cur.chunk_remaining == 33'd1) begin
                        do_boundary = 1'b1;
                    end
                end
            end else begin
                state_next.word_shift = {item.file_byte, cur.word_shift[31:8]};
                state_next.sub_count  = cur.sub_count + 4'd1;
                len = state_next.word_shift;

                unique case (cur.phase)
                    rwcp_pkg::PH_RIFF: begin
                        if (state_next.sub_count == 4'd4) begin
                            if (len != rwcp_pkg::TAG_RIFF) begin
                                emit   = 1'b1;
                                status = rwcp_pkg::STATUS_NOT_RIFF;
                            end else begin
                                state_next.phase     = rwcp_pkg::PH_RLEN;
                                state_next.sub_count = 4'd0;
                            end
                        end
                    end
                    rwcp_pkg::PH_RLEN: begin
                        if (state_next.sub_count == 4'd4) begin
                            state_next.riff_end  = {1'b0, len} + 33'd8;
                            state_next.phase     = rwcp_pkg::PH_WAVE;
                            state_next.sub_count = 4'd0;
                        end
                    end
                    rwcp_pkg::PH_WAVE: begin
                        if (state_next.sub_count == 4'd4) begin
                            if (len != rwcp_pkg::TAG_WAVE) begin
                                emit   = 1'b1;
                                status = rwcp_pkg::STATUS_NOT_WAVE;
                            end else begin
                                do_boundary = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // Chunk header: tag in the first four bytes, length in the next four.
                        if (state_next.sub_count == 4'd4) begin
                            state_next.chunk_tag = len;
                        end else if (state_next.sub_count >= 4'd8) begin
                            state_next.sub_count = 4'd0;
                            state_next.chunk_remaining =
                                ({1'b0, len} + 33'd1) & ~33'd1;
                            state_next.capture_left = 5'd0;
                            if (cur.chunk_tag == rwcp_pkg::TAG_FMT && !cur.found_flags[0]) begin
                                if (len < {24'd0, min_format_length}) begin
                                    emit   = 1'b1;
                                    status = rwcp_pkg::STATUS_FMT_SHORT;
                                end else begin
                                    state_next.found_flags[0] = 1'b1;
                                    state_next.capture_left =
                                        (len < {27'd0, rwcp_pkg::FORMAT_BYTES}) ?
                                        len[4:0] : rwcp_pkg::FORMAT_BYTES;
                                    state_next.capture_index = 4'd0;
                                    if (len == 32'd0 && cur.found_flags[1]
                                            && cur.data_len != 32'd0) begin
                                        emit   = 1'b1;
                                        status = rwcp_pkg::STATUS_COMPLETE;
                                    end
                                end
                            end else if (cur.chunk_tag == rwcp_pkg::TAG_DATA) begin
                                state_next.data_off       = state_next.byte_position[31:0];
                                state_next.data_len       = len;
                                state_next.found_flags[1] = 1'b1;
                                if (cur.found_flags[0]) begin
                                    emit   = 1'b1;
                                    status = rwcp_pkg::STATUS_COMPLETE;
                                end
                            end
                            if (!emit) begin
                                if (state_next.chunk_remaining == 33'd0) begin
                                    do_boundary = 1'b1;
                                end else begin
                                    state_next.phase = rwcp_pkg::PH_BODY;
                                end
                            end
                        end
                    end
                endcase
            end

            // Chunk boundary: stop at the RIFF end, otherwise start a new header.
            if (do_boundary && !emit) begin
                if (state_next.byte_position >= cur.riff_end) begin
                    emit   = 1'b1;
                    status = rwcp_pkg::STATUS_END;
                end else begin
                    state_next.phase     = rwcp_pkg::PH_HEAD;
                    state_next.sub_count = 4'd0;
                end
            end

            if (emit) begin
                state_next.phase = rwcp_pkg::PH_DONE;
            end
        end
    end

    // Result fields always show the state as it stands after this byte.
    always_comb begin
        result.status               = status;
        result.format_found         = state_next.found_flags[0];
        result.data_found           = state_next.found_flags[1];
        result.format_tag           = state_next.format_bytes[15:0];
        result.channel_count        = state_next.format_bytes[31:16];
        result.sample_rate          = state_next.format_bytes[63:32];
        result.avg_bytes_per_second = state_next.format_bytes[95:64];
        result.block_align          = state_next.format_bytes[111:96];
        result.bits_per_sample      = state_next.format_bytes[127:112];
        result.data_offset          = state_next.data_off;
        result.data_size            = state_next.data_len;
    end

    // Parse state advances on every accepted item.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/riff_wave_chunk_parser_top.sv
// A result is registered at the edge that accepts its byte, in the skid slot if one waits.
// Throughput: one byte per cycle while byte_stall is low; the parse state updates per byte.
// A two-entry result buffer keeps bytes flowing while one result waits; the input
// stalls only while both entries hold results.
// Reset: rst_n clears the parse state to idle and min_format_length to 16; bytes are
// ignored until one arrives with first_byte set.
`default_nettype none

module riff_wave_chunk_parser_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write_en,
    input  wire logic [7:0]            cfg_write_data,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire rwcp_pkg::byte_item_t  byte_item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output rwcp_pkg::result_item_t     result_item
);

    logic [7:0]             min_format_length_reg;
    logic                   accept;
    logic                   emit;
    rwcp_pkg::result_item_t core_result;
    logic                   result_valid_reg;
    rwcp_pkg::result_item_t result_reg;
    logic                   skid_valid_reg;
    rwcp_pkg::result_item_t skid_reg;
    logic                   new_result;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_format_length_reg <= rwcp_pkg::MIN_FORMAT_LENGTH_RESET;
        end else if (cfg_write_en) begin
            min_format_length_reg <= cfg_write_data;
        end
    end

    // An item is taken whenever the skid slot is free.
    assign byte_stall = skid_valid_reg;
    assign accept     = byte_valid && !byte_stall;
    assign new_result = accept && emit;

    rwcp_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .item              (byte_item),
        .min_format_length (min_format_length_reg),
        .emit              (emit),
        .result            (core_result)
    );

    // Result register with a skid slot behind it.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else if (!result_valid_reg || !result_stall) begin
            if (skid_valid_reg) begin
                result_valid_reg <= 1'b1;
                skid_valid_reg   <= 1'b0;
            end else begin
                result_valid_reg <= new_result;
            end
        end else if (new_result) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of both slots needs no reset.
    always_ff @(posedge clk) begin
        if (!result_valid_reg || !result_stall) begin
            if (skid_valid_reg) begin
                result_reg <= skid_reg;
            end else if (new_result) begin
                result_reg <= core_result;
            end
        end else if (new_result) begin
            skid_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    // The skid slot only fills behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid slot full while result register empty");

    // A result is only produced by an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid_reg && !skid_valid_reg && !accept) |=> !result_valid_reg)
        else $error("result appeared without an accepted item");

    // A waiting skid item moves forward as soon as the result is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !result_stall) |=> (!skid_valid_reg && result_valid_reg))
        else $error("skid item not forwarded");

endmodule

`default_nettype wire

// File: bench/testbench.sv
module testbench;

    // Status column value for rows whose result is left to the parse predictor.
    localparam logic [2:0] NO_CHECK = 3'd7;
    localparam int RANDOM_BYTES = 1250;
    localparam int FLOOR_PHASES = 6;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
        logic [2:0] status;
    } stim_row_t;

    typedef enum logic [1:0] {
        STALL_NEVER,
        STALL_HALF,
        STALL_MOSTLY
    } stall_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [7:0]             cfg_write_data = 8'd0;
    logic                   byte_valid = 1'b0;
    logic                   byte_stall;
    rwcp_pkg::byte_item_t   byte_item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    rwcp_pkg::result_item_t result_item;

    // Status typed in for the item on the bus, travelling alongside it.
    logic [2:0]   row_status = NO_CHECK;

    riff_wave_chunk_parser_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .byte_item      (byte_item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_item    (result_item)
    );

    always #5 clk = ~clk;

    // Parse predictor state.
    rwcp_pkg::phase_t wave_phase;
    logic [32:0]  file_pos;
    logic [32:0]  riff_limit;
    logic [31:0]  tag_shift;
    logic [31:0]  chunk_id;
    logic [32:0]  body_left;
    logic [127:0] fmt_capture;
    logic         have_fmt;
    logic         have_data;
    logic [31:0]  data_at;
    logic [31:0]  data_len;
    logic [3:0]   head_count;
    logic [4:0]   fmt_left;
    logic [4:0]   fmt_at;
    logic [7:0]   fmt_floor;

    rwcp_pkg::result_item_t summaries_due [$];
    logic [7:0]   file_bytes [$];
    int           parsed_bytes = 0;
    int           mismatches = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    bit           sender_gappy = 1'b1;
    stall_mode_t  stall_mode = STALL_NEVER;
    int           stall_mode_left = 0;

    // Directed items: bytes outside a file, a bad RIFF tag, a bad WAVE tag under the
    // largest RIFF length, and a RIFF length of zero that ends the file after WAVE.
    stim_row_t directed_rows [30] = '{
        '{8'hFF, 1'b0, NO_CHECK},
        '{8'hFF, 1'b1, NO_CHECK},
        '{8'h00, 1'b0, NO_CHECK},
        '{8'hFF, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, rwcp_pkg::STATUS_NOT_RIFF},
        '{8'h52, 1'b1, NO_CHECK},
        '{8'h49, 1'b0, NO_CHECK},
        '{8'h46, 1'b0, NO_CHECK},
        '{8'h46, 1'b0, NO_CHECK},
        '{8'hFF, 1'b0, NO_CHECK},
        '{8'hFF, 1'b0, NO_CHECK},
        '{8'hFF, 1'b0, NO_CHECK},
        '{8'hFF, 1'b0, NO_CHECK},
        '{8'h57, 1'b0, NO_CHECK},
        '{8'h41, 1'b0, NO_CHECK},
        '{8'h56, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, rwcp_pkg::STATUS_NOT_WAVE},
        '{8'h52, 1'b1, NO_CHECK},
        '{8'h49, 1'b0, NO_CHECK},
        '{8'h46, 1'b0, NO_CHECK},
        '{8'h46, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, NO_CHECK},
        '{8'h00, 1'b0, NO_CHECK},
        '{8'h57, 1'b0, NO_CHECK},
        '{8'h41, 1'b0, NO_CHECK},
        '{8'h56, 1'b0, NO_CHECK},
        '{8'h45, 1'b0, rwcp_pkg::STATUS_END},
        '{8'h45, 1'b0, NO_CHECK}
    };

    logic [7:0] floors [FLOOR_PHASES] = '{8'd16, 8'd0, 8'd255, 8'd14, 8'd16, 8'd24};

    function automatic void clear_parse();
        wave_phase = rwcp_pkg::PH_IDLE;
        file_pos = '0;
        riff_limit = '0;
        tag_shift = '0;
        chunk_id = '0;
        body_left = '0;
        fmt_capture = '0;
        have_fmt = 1'b0;
        have_data = 1'b0;
        data_at = '0;
        data_len = '0;
        head_count = '0;
        fmt_left = '0;
        fmt_at = '0;
    endfunction

    // Builds the summary from the current parse state and closes the file.
    function automatic rwcp_pkg::result_item_t summarise(input logic [2:0] status);
        rwcp_pkg::result_item_t r;
        r.status = status;
        r.format_found = have_fmt;
        r.data_found = have_data;
        r.format_tag = fmt_capture[15:0];
        r.channel_count = fmt_capture[31:16];
        r.sample_rate = fmt_capture[63:32];
        r.avg_bytes_per_second = fmt_capture[95:64];
        r.block_align = fmt_capture[111:96];
        r.bits_per_sample = fmt_capture[127:112];
        r.data_offset = data_at;
        r.data_size = data_len;
        wave_phase = rwcp_pkg::PH_DONE;
        return r;
    endfunction

    // At a chunk boundary the file either ends or a new chunk header begins.
    function automatic bit close_chunk(output rwcp_pkg::result_item_t res);
        res = '0;
        if (file_pos >= riff_limit)
        begin
            res = summarise(rwcp_pkg::STATUS_END);
            return 1'b1;
        end
        wave_phase = rwcp_pkg::PH_HEAD;
        head_count = '0;
        return 1'b0;
    endfunction

    // Advances the parse by one file byte; returns 1 when the byte yields a summary.
    function automatic bit parse_wave_byte(input rwcp_pkg::byte_item_t it,
                                           output rwcp_pkg::result_item_t res);
        logic [31:0] len;
        res = '0;
        if (it.first_byte)
        begin
            clear_parse();
            wave_phase = rwcp_pkg::PH_RIFF;
        end
        if (wave_phase == rwcp_pkg::PH_IDLE || wave_phase == rwcp_pkg::PH_DONE)
            return 1'b0;
        parsed_bytes++;
        if (file_pos != rwcp_pkg::POS_MAX)
            file_pos++;

        // Chunk body: format bytes are captured while any are still owed.
        if (wave_phase == rwcp_pkg::PH_BODY)
        begin
            if (fmt_left != 0)
            begin
                fmt_capture[fmt_at[3:0] * 8 +: 8] = it.file_byte;
                fmt_at++;
                fmt_left--;
                if (fmt_left == 0 && have_data && data_len != 0)
                begin
                    res = summarise(rwcp_pkg::STATUS_COMPLETE);
                    return 1'b1;
                end
            end
            body_left--;
            if (body_left == 0)
                return close_chunk(res);
            return 1'b0;
        end

        // Tags and lengths arrive little-endian through the shift word.
        tag_shift = {it.file_byte, tag_shift[31:8]};
        head_count++;
        case (wave_phase)
            rwcp_pkg::PH_RIFF:
            begin
                if (head_count == 4)
                begin
                    if (tag_shift != rwcp_pkg::TAG_RIFF)
                    begin
                        res = summarise(rwcp_pkg::STATUS_NOT_RIFF);
                        return 1'b1;
                    end
                    wave_phase = rwcp_pkg::PH_RLEN;
                    head_count = '0;
                end
            end
            rwcp_pkg::PH_RLEN:
            begin
                if (head_count == 4)
                begin
                    riff_limit = {1'b0, tag_shift} + 33'd8;
                    wave_phase = rwcp_pkg::PH_WAVE;
                    head_count = '0;
                end
            end
            rwcp_pkg::PH_WAVE:
            begin
                if (head_count == 4)
                begin
                    if (tag_shift != rwcp_pkg::TAG_WAVE)
                    begin
                        res = summarise(rwcp_pkg::STATUS_NOT_WAVE);
                        return 1'b1;
                    end
                    return close_chunk(res);
                end
            end
            rwcp_pkg::PH_HEAD:
            begin
                if (head_count == 4)
                    chunk_id = tag_shift;
                else if (head_count >= 8)
                begin
                    head_count = '0;
                    len = tag_shift;
                    body_left = ({1'b0, len} + 33'd1) & ~33'd1;
                    fmt_left = '0;
                    if (chunk_id == rwcp_pkg::TAG_FMT && !have_fmt)
                    begin
                        // Only the first fmt chunk is length-checked and captured.
                        if (len < {24'd0, fmt_floor})
                        begin
                            res = summarise(rwcp_pkg::STATUS_FMT_SHORT);
                            return 1'b1;
                        end
                        have_fmt = 1'b1;
                        fmt_left = (len < rwcp_pkg::FORMAT_BYTES) ? len[4:0]
                                                                  : rwcp_pkg::FORMAT_BYTES;
                        fmt_at = '0;
                        if (fmt_left == 0 && have_data && data_len != 0)
                        begin
                            res = summarise(rwcp_pkg::STATUS_COMPLETE);
                            return 1'b1;
                        end
                    end
                    else if (chunk_id == rwcp_pkg::TAG_DATA)
                    begin
                        data_at = file_pos[31:0];
                        data_len = len;
                        have_data = 1'b1;
                        if (have_fmt)
                        begin
                            res = summarise(rwcp_pkg::STATUS_COMPLETE);
                            return 1'b1;
                        end
                    end
                    if (body_left == 0)
                        return close_chunk(res);
                    wave_phase = rwcp_pkg::PH_BODY;
                end
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] got,
                                        input logic [31:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        end
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[i * 8 +: 8]);
    endfunction

    // Predict on every accepted byte, then check every accepted summary.
    always @(posedge clk)
    begin
        rwcp_pkg::result_item_t predicted;
        rwcp_pkg::result_item_t due;
        bit produced;
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                produced = parse_wave_byte(byte_item, predicted);
                if (row_status != NO_CHECK)
                begin
                    predicted = '0;
                    predicted.status = row_status;
                    produced = 1'b1;
                end
                if (produced)
                    summaries_due.push_back(predicted);
            end
            if (result_valid && !result_stall)
            begin
                if (summaries_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("summary with none outstanding: %h", result_item);
                end
                else
                begin
                    due = summaries_due.pop_front();
                    check_field("status", result_item.status, due.status);
                    check_field("format_found", result_item.format_found, due.format_found);
                    check_field("data_found", result_item.data_found, due.data_found);
                    check_field("format_tag", result_item.format_tag, due.format_tag);
                    check_field("channel_count", result_item.channel_count, due.channel_count);
                    check_field("sample_rate", result_item.sample_rate, due.sample_rate);
                    check_field("avg_bytes_per_second", result_item.avg_bytes_per_second,
                                due.avg_bytes_per_second);
                    check_field("block_align", result_item.block_align, due.block_align);
                    check_field("bits_per_sample", result_item.bits_per_sample,
                                due.bits_per_sample);
                    check_field("data_offset", result_item.data_offset, due.data_offset);
                    check_field("data_size", result_item.data_size, due.data_size);
                end
            end
        end
    end

    // Receiver back-pressure: the stall pattern switches mode whenever its hold count runs out.
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 2));
            stall_mode_left <= $urandom_range(40, 300);
        end
        else
            stall_mode_left <= stall_mode_left - 1;
        case (stall_mode)
            STALL_NEVER:  result_stall <= 1'b0;
            STALL_HALF:   result_stall <= 1'($urandom_range(0, 1));
            default:      result_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Watchdog on the overall run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Offers one byte and holds it until it is taken; with sender_gappy set, bursts are broken by random gaps.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [2:0] status);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (sender_gappy)
            begin
                gap = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    byte_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        burst_left--;
        byte_item <= '{file_byte: b, first_byte: first};
        row_status <= status;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    // Holds the sender off until every outstanding summary has been taken.
    task automatic drain_summaries();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (summaries_due.size() != 0);
    endtask

    task automatic write_fmt_floor(input logic [7:0] value);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        fmt_floor = value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Builds a mostly well-formed file with random chunks, occasionally broken.
    task automatic build_wave_file();
        int n_chunks;
        int body_n;
        int keep;
        bit cut;
        logic [31:0] tag;
        logic [31:0] len;
        logic [31:0] riff_len;
        file_bytes.delete();
        put_word(($urandom_range(0, 24) == 0)
                 ? rwcp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(0, 31))
                 : rwcp_pkg::TAG_RIFF);
        put_word(32'd0);
        put_word(($urandom_range(0, 24) == 0)
                 ? rwcp_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(0, 31))
                 : rwcp_pkg::TAG_WAVE);
        n_chunks = $urandom_range(1, 4);
        cut = 1'b0;
        for (int c = 0; c < n_chunks && !cut; c++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    tag = rwcp_pkg::TAG_FMT;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: len = 32'd16;
                        4:          len = 32'd18;
                        5:          len = $urandom_range(0, 20);
                        6:          len = {24'd0, fmt_floor};
                        7:          len = {24'd0, fmt_floor} - 32'd1;
                        8:          len = 32'd255;
                        default:    len = 32'hFFFF_FFFF;
                    endcase
                end
                3, 4, 5:
                begin
                    tag = rwcp_pkg::TAG_DATA;
                    case ($urandom_range(0, 7))
                        0, 1:    len = $urandom_range(1, 8);
                        2:       len = 32'd0;
                        3:       len = 32'hFFFF_FFFF;
                        4:       len = $urandom;
                        default: len = $urandom_range(0, 3);
                    endcase
                end
                default:
                begin
                    tag = $urandom;
                    len = $urandom_range(0, 9);
                end
            endcase
            put_word(tag);
            put_word(len);
            // Long bodies are cut short and the file is abandoned there.
            if (len > 32'd64)
            begin
                body_n = $urandom_range(0, 30);
                cut = 1'b1;
            end
            else
                body_n = (int'(len) + 1) & ~1;
            repeat (body_n) file_bytes.push_back(8'($urandom));
        end
        case ($urandom_range(0, 7))
            0:       riff_len = $urandom_range(0, file_bytes.size());
            1:       riff_len = 32'hFFFF_FFFF;
            2:       riff_len = $urandom;
            default: riff_len = file_bytes.size() - 8;
        endcase
        for (int i = 0; i < 4; i++)
            file_bytes[4 + i] = riff_len[i * 8 +: 8];
        if ($urandom_range(0, 9) == 0)
        begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep)
                void'(file_bytes.pop_back());
        end
    endtask

    initial
    begin
        int phase_start;
        clear_parse();
        fmt_floor = rwcp_pkg::MIN_FORMAT_LENGTH_RESET;
        floors[4] = 8'($urandom);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset value of the fmt floor.
        foreach (directed_rows[i])
            send_byte(directed_rows[i].file_byte, directed_rows[i].first_byte,
                      directed_rows[i].status);

        // Random files, one floor setting per phase, written once the block is quiet.
        for (int p = 0; p < FLOOR_PHASES; p++)
        begin
            drain_summaries();
            repeat (4) @(posedge clk);
            write_fmt_floor(floors[p]);
            sender_gappy = (p % 3 != 1);
            phase_start = parsed_bytes;
            while (parsed_bytes - phase_start < RANDOM_BYTES / FLOOR_PHASES)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 8))
                        send_byte(8'($urandom), $urandom_range(0, 5) == 0, NO_CHECK);
                end
                else
                begin
                    build_wave_file();
                    foreach (file_bytes[i])
                        send_byte(file_bytes[i], i == 0, NO_CHECK);
                end
                if ($urandom_range(0, 39) == 0)
                    drain_summaries();
            end
        end

        drain_summaries();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && summaries_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: riff_wave_chunk_parser_top.f
rtl/rwcp_pkg.sv
rtl/rwcp_core.sv
rtl/riff_wave_chunk_parser_top.sv
bench/testbench.sv
